/* design/pprq_pkg.sv */
// Package for the pending packet release queue.
// Holds the field widths, the stored entry layout and the request and result codes.
// Has no dependencies.
package pprq_pkg;

  localparam int unsigned HandleW = 16;
  localparam int unsigned LengthW = 11;
  localparam int unsigned IpW     = 32;
  localparam int unsigned MacW    = 48;

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_RESOLVE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ENQUEUED = 2'd0,
    KIND_DROPPED  = 2'd1,
    KIND_RELEASED = 2'd2,
    KIND_NO_MATCH = 2'd3
  } kind_e;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [LengthW-1:0] length;
    logic [IpW-1:0]     ip;
  } entry_t;

endpackage

/* design/pending_packet_release_queue_unit.sv */
// Top level of the pending packet release queue: a ring of packets waiting for
// address resolution. Depends on pprq_pkg, pprq_entry_ram and pprq_seq.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o req_type, packet_handle, packet_length,
//                                             dest_ip, resolved_mac
//   out      output     out_valid_o/out_stall_i result_kind, out_handle, out_length,
//                                             out_mac, last
//
// An enqueue's result shows in the cycle after the enqueue is taken.
// A resolve reads and compares each slot from head to tail on the single memory
// read port and IP comparator, then retires freed head slots, then gives its last result.
// Reset empties the ring; the entry memory is not cleared.
// A stalled result register holds new items off; the walk waits only when a
// second release is ready while the register is still full.
module pending_packet_release_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [pprq_pkg::HandleW-1:0]  packet_handle_i,
  input  logic [pprq_pkg::LengthW-1:0]  packet_length_i,
  input  logic [pprq_pkg::IpW-1:0]      dest_ip_i,
  input  logic [pprq_pkg::MacW-1:0]     resolved_mac_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    result_kind_o,
  output logic [pprq_pkg::HandleW-1:0]  out_handle_o,
  output logic [pprq_pkg::LengthW-1:0]  out_length_o,
  output logic [pprq_pkg::MacW-1:0]     out_mac_o,
  output logic                          last_o
);
  import pprq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  entry_t          rd_data;
  kind_e           kind;

  pprq_entry_ram #(
    .DEPTH (DEPTH),
    .IdxW  (IdxW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pprq_seq #(
    .DEPTH (DEPTH),
    .IdxW  (IdxW)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .packet_handle_i (packet_handle_i),
    .packet_length_i (packet_length_i),
    .dest_ip_i       (dest_ip_i),
    .resolved_mac_i  (resolved_mac_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (kind),
    .out_handle_o    (out_handle_o),
    .out_length_o    (out_length_o),
    .out_mac_o       (out_mac_o),
    .last_o          (last_o),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data)
  );

  assign result_kind_o = kind;

endmodule

/* design/pprq_entry_ram.sv */
// Entry memory of the pending packet ring: one write port, one read port,
// registered read data. Depends on pprq_pkg.
module pprq_entry_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  pprq_pkg::entry_t  wr_data_i,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  output pprq_pkg::entry_t  rd_data_o
);
  import pprq_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/pprq_seq.sv */
// Sequencer of the pending packet ring: pointers, pending marks, slot walk with one
// shared IP comparator, and the result register. Depends on pprq_pkg.
module pprq_seq #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [pprq_pkg::HandleW-1:0]  packet_handle_i,
  input  logic [pprq_pkg::LengthW-1:0]  packet_length_i,
  input  logic [pprq_pkg::IpW-1:0]      dest_ip_i,
  input  logic [pprq_pkg::MacW-1:0]     resolved_mac_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pprq_pkg::kind_e               result_kind_o,
  output logic [pprq_pkg::HandleW-1:0]  out_handle_o,
  output logic [pprq_pkg::LengthW-1:0]  out_length_o,
  output logic [pprq_pkg::MacW-1:0]     out_mac_o,
  output logic                          last_o,
  output logic                          wr_en_o,
  output logic [IdxW-1:0]               wr_addr_o,
  output pprq_pkg::entry_t              wr_data_o,
  output logic                          rd_en_o,
  output logic [IdxW-1:0]               rd_addr_o,
  input  pprq_pkg::entry_t              rd_data_i
);
  import pprq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_HEAD,
    S_FIN
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     head_q;
  logic [IdxW-1:0]     tail_q;
  logic [IdxW-1:0]     cur_q;
  logic [DEPTH-1:0]    pend_q;
  logic [IpW-1:0]      ip_q;
  logic [MacW-1:0]     mac_q;
  logic                hold_valid_q;
  logic [HandleW-1:0]  hold_handle_q;
  logic [LengthW-1:0]  hold_length_q;

  logic                out_valid_q;
  kind_e               out_kind_q;
  logic [HandleW-1:0]  out_handle_q;
  logic [LengthW-1:0]  out_length_q;
  logic [MacW-1:0]     out_mac_q;
  logic                out_last_q;

  logic                out_free;
  logic                in_acc;
  logic                full;
  logic                hit;
  logic [IdxW-1:0]     tail_nxt;
  logic [IdxW-1:0]     head_nxt;
  logic [IdxW-1:0]     cur_nxt;

  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    if (idx == IdxW'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    in_stall_o = (state_q != S_IDLE) || !out_free;
    in_acc     = in_valid_i && !in_stall_o;
    tail_nxt   = ring_next(tail_q);
    head_nxt   = ring_next(head_q);
    cur_nxt    = ring_next(cur_q);
    full       = (tail_nxt == head_q);
    hit        = pend_q[cur_q] && (rd_data_i.ip == ip_q);
    wr_en_o    = in_acc && (req_type_i == REQ_ENQUEUE) && !full;
    wr_addr_o  = tail_q;
    wr_data_o  = '{handle: packet_handle_i, length: packet_length_i, ip: dest_ip_i};
    rd_en_o    = (state_q == S_READ) && (cur_q != tail_q);
    rd_addr_o  = cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      cur_q         <= '0;
      pend_q        <= '0;
      hold_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= KIND_ENQUEUED;
      out_last_q    <= 1'b0;
      out_handle_q  <= '0;
      out_length_q  <= '0;
      out_mac_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (req_type_i == REQ_ENQUEUE) begin
              out_valid_q  <= 1'b1;
              out_handle_q <= '0;
              out_length_q <= '0;
              out_mac_q    <= '0;
              out_last_q   <= 1'b1;
              if (full) begin
                out_kind_q <= KIND_DROPPED;
              end else begin
                out_kind_q     <= KIND_ENQUEUED;
                pend_q[tail_q] <= 1'b1;
                tail_q         <= tail_nxt;
              end
            end else begin
              ip_q         <= dest_ip_i;
              mac_q        <= resolved_mac_i;
              cur_q        <= head_q;
              hold_valid_q <= 1'b0;
              state_q      <= S_READ;
            end
          end
        end
        S_READ: begin
          if (cur_q == tail_q) begin
            state_q <= S_HEAD;
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (!(hit && hold_valid_q && !out_free)) begin
            if (hit) begin
              if (hold_valid_q) begin
                out_valid_q  <= 1'b1;
                out_kind_q   <= KIND_RELEASED;
                out_handle_q <= hold_handle_q;
                out_length_q <= hold_length_q;
                out_mac_q    <= mac_q;
                out_last_q   <= 1'b0;
              end
              hold_valid_q   <= 1'b1;
              hold_handle_q  <= rd_data_i.handle;
              hold_length_q  <= rd_data_i.length;
              pend_q[cur_q]  <= 1'b0;
            end
            cur_q   <= cur_nxt;
            state_q <= S_READ;
          end
        end
        S_HEAD: begin
          if ((head_q != tail_q) && !pend_q[head_q]) begin
            head_q <= head_nxt;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b1;
            if (hold_valid_q) begin
              out_kind_q   <= KIND_RELEASED;
              out_handle_q <= hold_handle_q;
              out_length_q <= hold_length_q;
              out_mac_q    <= mac_q;
            end else begin
              out_kind_q   <= KIND_NO_MATCH;
              out_handle_q <= '0;
              out_length_q <= '0;
              out_mac_q    <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign out_handle_o  = out_handle_q;
  assign out_length_o  = out_length_q;
  assign out_mac_o     = out_mac_q;
  assign last_o        = out_last_q;

endmodule

/* design/pprq_checker.sv */
// Port-level checks for the pending packet release queue, bound to the top level.
// Depends on pprq_pkg and pending_packet_release_queue_unit.
module pprq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          req_type_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    result_kind_o,
  input logic [pprq_pkg::HandleW-1:0]  out_handle_o,
  input logic [pprq_pkg::LengthW-1:0]  out_length_o,
  input logic [pprq_pkg::MacW-1:0]     out_mac_o,
  input logic                          last_o
);
  import pprq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_back_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("item taken while result register is stalled");

  a_enq_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_ENQUEUE) |=>
      out_valid_o && last_o &&
      ((result_kind_o == KIND_ENQUEUED) || (result_kind_o == KIND_DROPPED)))
    else $error("enqueue result missing");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != KIND_RELEASED) |->
      last_o && (out_handle_o == '0) && (out_length_o == '0) && (out_mac_o == '0))
    else $error("non-release result malformed");

endmodule

bind pending_packet_release_queue_unit pprq_checker u_pprq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .req_type_i    (req_type_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_kind_o (result_kind_o),
  .out_handle_o  (out_handle_o),
  .out_length_o  (out_length_o),
  .out_mac_o     (out_mac_o),
  .last_o        (last_o)
);
